[sv/frr_pkg.sv]
// Package: shared types, codes and constants of the framed reply receiver.
package frr_pkg;

    localparam int MAX_REPLY_BYTES = 256;
    localparam int BSC_W           = $clog2(MAX_REPLY_BYTES);

    localparam int BYTE_W   = 7;
    localparam int IDX_W    = 8;
    localparam int EV_W     = 2;
    localparam int STAT_W   = 3;
    localparam int REASON_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINAL      = 1'b1;

    localparam logic [BYTE_W-1:0] CFG_TYPE_RESET     = 7'd51;
    localparam logic [BYTE_W-1:0] CFG_TERMINAL_RESET = 7'd1;

    localparam logic [BYTE_W-1:0] CH_STX     = 7'h02;
    localparam logic [BYTE_W-1:0] CH_ETX     = 7'h03;
    localparam logic [BYTE_W-1:0] CH_ACK     = 7'h06;
    localparam logic [BYTE_W-1:0] CH_NAK     = 7'h15;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 7'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [BYTE_W-1:0] ABORT_TYPE = 7'h32;

    localparam logic [EV_W-1:0] EV_NONE = 2'd0;
    localparam logic [EV_W-1:0] EV_ACK  = 2'd1;
    localparam logic [EV_W-1:0] EV_NAK  = 2'd2;
    localparam logic [EV_W-1:0] EV_STX  = 2'd3;

    localparam logic [STAT_W-1:0] ST_PENDING  = 3'd0;
    localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd2;
    localparam logic [STAT_W-1:0] ST_ABORTED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;

    localparam logic [REASON_W-1:0] RSN_USER       = 3'd0;
    localparam logic [REASON_W-1:0] RSN_TIMEOUT    = 3'd1;
    localparam logic [REASON_W-1:0] RSN_HOST       = 3'd2;
    localparam logic [REASON_W-1:0] RSN_CURRENCY   = 3'd3;
    localparam logic [REASON_W-1:0] RSN_NOT_CREDIT = 3'd4;
    localparam logic [REASON_W-1:0] RSN_UNKNOWN    = 3'd5;

    typedef struct packed {
        logic              clear;
        logic [BYTE_W-1:0] sb;
        logic [EV_W-1:0]   ev;
        logic              is_stx;
        logic              is_etx;
        logic              is_abort_type;
        logic              type_match;
        logic              tens_match;
        logic              units_match;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

[sv/frr_if.sv]
// Interfaces: input and result channels with valid/ready handshake.
interface frr_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [frr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface frr_out_if;
    logic                        valid;
    logic                        ready;
    logic [frr_pkg::EV_W-1:0]     line_event;
    logic [frr_pkg::STAT_W-1:0]   frame_status;
    logic [frr_pkg::REASON_W-1:0] abort_reason;
    logic [frr_pkg::IDX_W-1:0]    frame_index;
    logic [frr_pkg::BYTE_W-1:0]   stored_byte;
    logic [frr_pkg::BYTE_W-1:0]   computed_check;

    modport source (output valid, output line_event, output frame_status,
                    output abort_reason, output frame_index, output stored_byte,
                    output computed_check, input ready);
    modport sink (input valid, input line_event, input frame_status,
                  input abort_reason, input frame_index, input stored_byte,
                  input computed_check, output ready);
endinterface

[sv/frr_front.sv]
// Front end: configuration registers and classification of accepted items.
module frr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    frr_in_if.sink                          in_ch,
    input  logic                            cfg_we,
    input  logic [frr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frr_pkg::BYTE_W-1:0]      cfg_data,
    input  frr_pkg::q_status_t              q_status,
    output logic                            push,
    output frr_pkg::item_t                  item
);

    logic [frr_pkg::BYTE_W-1:0] type_reg;
    logic [frr_pkg::BYTE_W-1:0] terminal_reg;

    logic [frr_pkg::BYTE_W-1:0] tn_mod;
    logic [14:0]                tens_prod;
    logic [3:0]                 tens;
    logic [frr_pkg::BYTE_W-1:0] units_wide;
    logic [frr_pkg::BYTE_W-1:0] tens_char;
    logic [frr_pkg::BYTE_W-1:0] units_char;
    logic [frr_pkg::BYTE_W-1:0] sb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg     <= frr_pkg::CFG_TYPE_RESET;
            terminal_reg <= frr_pkg::CFG_TERMINAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                frr_pkg::CFG_EXPECTED_TYPE: type_reg     <= cfg_data;
                frr_pkg::CFG_TERMINAL:      terminal_reg <= cfg_data;
                default:                    type_reg     <= type_reg;
            endcase
        end
    end

    // two decimal digits of the terminal number modulo 100
    always_comb
    begin
        tn_mod     = (terminal_reg >= 7'd100) ? (terminal_reg - 7'd100) : terminal_reg;
        tens_prod  = {8'd0, tn_mod} * 15'd205;
        tens       = tens_prod[14:11];
        units_wide = tn_mod - ({3'd0, tens} * 7'd10);
        tens_char  = frr_pkg::CH_ZERO + {3'd0, tens};
        units_char = frr_pkg::CH_ZERO + {3'd0, units_wide[3:0]};
    end

    assign sb = (in_ch.rx_byte == '0) ? frr_pkg::CH_SPACE : in_ch.rx_byte;

    always_comb
    begin
        item.clear         = in_ch.kind;
        item.sb            = in_ch.kind ? '0 : sb;
        item.is_stx        = (sb == frr_pkg::CH_STX);
        item.is_etx        = (sb == frr_pkg::CH_ETX);
        item.is_abort_type = (sb == frr_pkg::ABORT_TYPE);
        item.type_match    = (sb == type_reg);
        item.tens_match    = (sb == tens_char);
        item.units_match   = (sb == units_char);
        priority if (sb == frr_pkg::CH_ACK)
            item.ev = frr_pkg::EV_ACK;
        else if (sb == frr_pkg::CH_NAK)
            item.ev = frr_pkg::EV_NAK;
        else if (sb == frr_pkg::CH_STX)
            item.ev = frr_pkg::EV_STX;
        else
            item.ev = frr_pkg::EV_NONE;
    end

    assign in_ch.ready = !q_status.full;
    assign push        = in_ch.valid && !q_status.full;

endmodule

[sv/frr_queue.sv]
// Queue: two-entry buffer of classified items between front and back end.
module frr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  frr_pkg::item_t     push_item,
    input  logic               pop,
    output frr_pkg::item_t     head_item,
    output frr_pkg::q_status_t status
);

    frr_pkg::item_t mem [2];

    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_item    = mem[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

`ifndef SYNTH
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

[sv/frr_back.sv]
// Back end: frame state update and result register.
module frr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  frr_pkg::q_status_t q_status,
    input  frr_pkg::item_t     head_item,
    output logic               pop,
    frr_out_if.source          out_ch
);

    logic                          open_reg,   open_next;
    logic [frr_pkg::IDX_W-1:0]     off_reg,    off_next;
    logic [frr_pkg::BYTE_W-1:0]    run_reg,    run_next;
    logic                          hm_reg,     hm_next;
    logic                          ab_reg,     ab_next;
    logic                          aw_reg,     aw_next;
    logic [frr_pkg::BYTE_W-1:0]    rh_reg,     rh_next;
    logic [frr_pkg::BYTE_W-1:0]    rl_reg,     rl_next;
    logic [frr_pkg::BSC_W-1:0]     bsc_reg,    bsc_next;
    logic [frr_pkg::STAT_W-1:0]    status_reg, status_next;

    logic                          ov_reg,     ov_next;
    logic [frr_pkg::EV_W-1:0]      ev_reg,     ev_next;
    logic [frr_pkg::STAT_W-1:0]    ostat_reg,  ostat_next;
    logic [frr_pkg::REASON_W-1:0]  rsn_reg,    rsn_next;
    logic [frr_pkg::IDX_W-1:0]     idx_reg,    idx_next;
    logic [frr_pkg::BYTE_W-1:0]    sb_reg,     sb_next;
    logic [frr_pkg::BYTE_W-1:0]    chk_reg,    chk_next;

    localparam logic [frr_pkg::BSC_W-1:0] BSC_LAST =
        frr_pkg::BSC_W'(frr_pkg::MAX_REPLY_BYTES - 1);

    function automatic logic [4:0] hex_nibble(input logic [frr_pkg::BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 7'h30 && c <= 7'h39)
            r = {1'b1, 4'(c - 7'h30)};
        else if (c >= 7'h41 && c <= 7'h46)
            r = {1'b1, 4'(c - 7'h37)};
        else if (c >= 7'h61 && c <= 7'h66)
            r = {1'b1, 4'(c - 7'h57)};
        return r;
    endfunction

    function automatic logic [frr_pkg::REASON_W-1:0] reason_code(
        input logic [frr_pkg::BYTE_W-1:0] hi_c,
        input logic [frr_pkg::BYTE_W-1:0] lo_c);
        logic [4:0]                   hi;
        logic [4:0]                   lo;
        logic [frr_pkg::REASON_W-1:0] r;
        hi = hex_nibble(hi_c);
        lo = hex_nibble(lo_c);
        r  = frr_pkg::RSN_UNKNOWN;
        if (hi[4] && lo[4])
        begin
            unique case ({hi[3:0], lo[3:0]})
                8'h17:   r = frr_pkg::RSN_USER;
                8'h18:   r = frr_pkg::RSN_TIMEOUT;
                8'h08:   r = frr_pkg::RSN_HOST;
                8'h0D:   r = frr_pkg::RSN_CURRENCY;
                8'h30:   r = frr_pkg::RSN_NOT_CREDIT;
                default: r = frr_pkg::RSN_UNKNOWN;
            endcase
        end
        return r;
    endfunction

    assign pop = !q_status.empty && (!ov_reg || out_ch.ready);

    always_comb
    begin
        open_next   = open_reg;
        off_next    = off_reg;
        run_next    = run_reg;
        hm_next     = hm_reg;
        ab_next     = ab_reg;
        aw_next     = aw_reg;
        rh_next     = rh_reg;
        rl_next     = rl_reg;
        bsc_next    = bsc_reg;
        status_next = status_reg;
        ev_next     = frr_pkg::EV_NONE;
        idx_next    = '0;
        chk_next    = '0;
        sb_next     = head_item.sb;

        if (head_item.clear)
        begin
            open_next   = 1'b0;
            off_next    = '0;
            run_next    = '0;
            hm_next     = 1'b0;
            ab_next     = 1'b0;
            aw_next     = 1'b0;
            rh_next     = '0;
            rl_next     = '0;
            bsc_next    = '0;
            status_next = frr_pkg::ST_PENDING;
        end
        else if (status_reg == frr_pkg::ST_PENDING)
        begin
            if (bsc_reg >= BSC_LAST)
            begin
                status_next = frr_pkg::ST_OVERFLOW;
                open_next   = 1'b0;
            end
            else
            begin
                bsc_next = bsc_reg + 1'b1;
                ev_next  = head_item.ev;
                if (head_item.is_stx)
                begin
                    open_next = 1'b1;
                    off_next  = '0;
                    run_next  = '0;
                    hm_next   = 1'b1;
                    ab_next   = 1'b0;
                    aw_next   = 1'b0;
                    rh_next   = '0;
                    rl_next   = '0;
                end
                else if (open_reg)
                begin
                    off_next = (off_reg == '1) ? off_reg : off_reg + 1'b1;
                    idx_next = off_next;
                    if (aw_reg)
                    begin
                        chk_next    = run_reg;
                        status_next = (head_item.sb == run_reg) ? frr_pkg::ST_ACCEPTED
                                                                : frr_pkg::ST_MISMATCH;
                        open_next   = 1'b0;
                    end
                    else
                    begin
                        run_next = run_reg ^ head_item.sb;
                        chk_next = run_next;
                        if (off_next == 8'd1)
                        begin
                            if (head_item.is_abort_type)
                                ab_next = 1'b1;
                            else
                                hm_next = head_item.type_match;
                        end
                        else if (ab_reg)
                        begin
                            if (off_next == 8'd4)
                                rh_next = head_item.sb;
                            else if (off_next == 8'd5)
                                rl_next = head_item.sb;
                            else if (off_next == 8'd6)
                            begin
                                status_next = frr_pkg::ST_ABORTED;
                                open_next   = 1'b0;
                            end
                        end
                        else if (off_next == 8'd2)
                            hm_next = hm_reg && head_item.tens_match;
                        else if (off_next == 8'd3)
                            hm_next = hm_reg && head_item.units_match;
                        else if (hm_reg && head_item.is_etx)
                            aw_next = 1'b1;
                    end
                end
            end
        end

        ostat_next = status_next;
        rsn_next   = (status_next == frr_pkg::ST_ABORTED) ? reason_code(rh_next, rl_next)
                                                         : frr_pkg::RSN_USER;
        ov_next    = pop || (ov_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            off_reg    <= '0;
            run_reg    <= '0;
            hm_reg     <= 1'b0;
            ab_reg     <= 1'b0;
            aw_reg     <= 1'b0;
            rh_reg     <= '0;
            rl_reg     <= '0;
            bsc_reg    <= '0;
            status_reg <= frr_pkg::ST_PENDING;
            ov_reg     <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            if (pop)
            begin
                open_reg   <= open_next;
                off_reg    <= off_next;
                run_reg    <= run_next;
                hm_reg     <= hm_next;
                ab_reg     <= ab_next;
                aw_reg     <= aw_next;
                rh_reg     <= rh_next;
                rl_reg     <= rl_next;
                bsc_reg    <= bsc_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg    <= ev_next;
            ostat_reg <= ostat_next;
            rsn_reg   <= rsn_next;
            idx_reg   <= idx_next;
            sb_reg    <= sb_next;
            chk_reg   <= chk_next;
        end
    end

    assign out_ch.valid          = ov_reg;
    assign out_ch.line_event     = ev_reg;
    assign out_ch.frame_status   = ostat_reg;
    assign out_ch.abort_reason   = rsn_reg;
    assign out_ch.frame_index    = idx_reg;
    assign out_ch.stored_byte    = sb_reg;
    assign out_ch.computed_check = chk_reg;

`ifndef SYNTH
    a_open_pending: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (status_reg == frr_pkg::ST_PENDING))
        else $error("frame open after final status");
    a_await_header: assert property (@(posedge clk) disable iff (!rst_n)
        aw_reg |-> (open_reg || status_reg != frr_pkg::ST_PENDING))
        else $error("check byte awaited outside a frame");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bsc_reg <= BSC_LAST)
        else $error("byte count past limit");
    a_reason_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ostat_reg != frr_pkg::ST_ABORTED) |-> (rsn_reg == frr_pkg::RSN_USER))
        else $error("abort reason set without abort");
`endif

endmodule

[sv/framed_reply_receiver_top.sv]
// Top level: framed reply receiver with decoupled front end, queue and back end.
//
//  channel   direction  handshake        payload
//  in_ch     sink       valid/ready      kind, rx_byte
//  out_ch    source     valid/ready      line_event, frame_status, abort_reason,
//                                        frame_index, stored_byte, computed_check
//  cfg       write      cfg_we           cfg_index, cfg_data
//
//  One item per cycle sustained while in_ch offers items and out_ch accepts; a result
//  passes through the queue and is held in the output register until out_ch takes it.
//  The frame state update in the back end handles one item per pop.
//  rst_n clears all control and frame state at once; no clearing pass.
//  A two-entry queue and the output register absorb output stalls; in_ch.ready
//  drops when the queue is full.
module framed_reply_receiver_top (
    input  logic                          clk,
    input  logic                          rst_n,
    frr_in_if.sink                        in_ch,
    frr_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [frr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [frr_pkg::BYTE_W-1:0]    cfg_data
);

    frr_pkg::q_status_t q_status;
    frr_pkg::item_t     push_item;
    frr_pkg::item_t     head_item;
    logic               push;
    logic               pop;

    frr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .item      (push_item)
    );

    frr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    frr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_item (head_item),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule
